/* hdl/zsr_pkg.sv */
// Shared types, constants and group arithmetic for the zero-sum reach-set block.
`default_nettype none

package zsr_pkg;

    // Number of elements in Z5^3 and the width of one reach set.
    localparam int GROUP_SIZE = 125;

    // One bit per group element; bit 25x+5y+z stands for element (x,y,z).
    typedef logic [GROUP_SIZE-1:0] set_t;

    // A set that holds only the zero element, and the empty set.
    localparam set_t ZERO_ONLY_SET = {{(GROUP_SIZE-1){1'b0}}, 1'b1};
    localparam set_t EMPTY_SET     = '0;

    // One coordinate of a group element, always below five.
    typedef logic [2:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } elem_coord_t;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic result;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic restart;
        logic count_zero;
        logic count_last;
        logic hit;
    } dp_stat_t;

    // Split an element code into its three coordinates, each taken mod 5.
    function automatic elem_coord_t elem_coords(input logic [6:0] code);
        elem_coord_t c;
        logic [6:0]  r;
        logic [6:0]  r2;
        c = '0;
        if (code >= 7'd125)
        begin
            c.x = 3'd0;
            r   = code - 7'd125;
        end
        else if (code >= 7'd100)
        begin
            c.x = 3'd4;
            r   = code - 7'd100;
        end
        else if (code >= 7'd75)
        begin
            c.x = 3'd3;
            r   = code - 7'd75;
        end
        else if (code >= 7'd50)
        begin
            c.x = 3'd2;
            r   = code - 7'd50;
        end
        else if (code >= 7'd25)
        begin
            c.x = 3'd1;
            r   = code - 7'd25;
        end
        else
        begin
            c.x = 3'd0;
            r   = code;
        end
        if (r >= 7'd20)
        begin
            c.y = 3'd4;
            r2  = r - 7'd20;
        end
        else if (r >= 7'd15)
        begin
            c.y = 3'd3;
            r2  = r - 7'd15;
        end
        else if (r >= 7'd10)
        begin
            c.y = 3'd2;
            r2  = r - 7'd10;
        end
        else if (r >= 7'd5)
        begin
            c.y = 3'd1;
            r2  = r - 7'd5;
        end
        else
        begin
            c.y = 3'd0;
            r2  = r;
        end
        c.z = r2[2:0];
        return c;
    endfunction

    // Cyclic rotation of five bits: bit i of the result is bit (i - amt) mod 5.
    function automatic logic [4:0] rot5(input logic [4:0] v, input coord_t amt);
        logic [4:0] o;
        case (amt)
            3'd0:    o = v;
            3'd1:    o = {v[3:0], v[4]};
            3'd2:    o = {v[2:0], v[4:3]};
            3'd3:    o = {v[1:0], v[4:2]};
            3'd4:    o = {v[0], v[4:1]};
            default: o = v;
        endcase
        return o;
    endfunction

    // Translate every member of a set by an element, one coordinate at a time.
    function automatic set_t shift_set(input set_t s, input elem_coord_t e);
        set_t       t1;
        set_t       t2;
        set_t       t3;
        logic [4:0] g;
        t1 = '0;
        t2 = '0;
        t3 = '0;
        g  = '0;
        // Rotate z within each run of five.
        for (int a = 0; a < 5; a++)
        begin
            for (int b = 0; b < 5; b++)
            begin
                t1[a*25 + b*5 +: 5] = rot5(s[a*25 + b*5 +: 5], e.z);
            end
        end
        // Rotate y across the runs of one block.
        for (int a = 0; a < 5; a++)
        begin
            for (int c = 0; c < 5; c++)
            begin
                for (int b = 0; b < 5; b++)
                begin
                    g[b] = t1[a*25 + b*5 + c];
                end
                g = rot5(g, e.y);
                for (int b = 0; b < 5; b++)
                begin
                    t2[a*25 + b*5 + c] = g[b];
                end
            end
        end
        // Rotate x across the blocks.
        for (int b = 0; b < 5; b++)
        begin
            for (int c = 0; c < 5; c++)
            begin
                for (int a = 0; a < 5; a++)
                begin
                    g[a] = t2[a*25 + b*5 + c];
                end
                g = rot5(g, e.x);
                for (int a = 0; a < 5; a++)
                begin
                    t3[a*25 + b*5 + c] = g[a];
                end
            end
        end
        return t3;
    endfunction

endpackage

`default_nettype wire

/* hdl/zsr_req_if.sv */
// Request channel: valid, ready and the item fields.
`default_nettype none

interface zsr_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [6:0] element;
    logic [2:0] copies;

    modport source (output valid, output func, output element, output copies, input ready);
    modport sink   (input valid, input func, input element, input copies, output ready);
endinterface

`default_nettype wire

/* hdl/zsr_rsp_if.sv */
// Response channel: valid, ready and the result field.
`default_nettype none

interface zsr_rsp_if;
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, output accepted, input ready);
    modport sink   (input valid, input accepted, output ready);
endinterface

`default_nettype wire

/* hdl/zsr_ctrl.sv */
// Controller state machine: sequences copies, commits results and runs the handshakes.
`default_nettype none

module zsr_ctrl
    import zsr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      out_ready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd,
    output logic           in_ready,
    output logic           out_valid
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   done_now;
    logic   slot_free;

    // The item ends once it is a restart, has no copies left, hits zero or is on its last copy.
    assign done_now  = stat.restart | stat.count_zero | stat.hit | stat.count_last;
    assign slot_free = !out_valid_reg | out_ready;

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_APPLY:
            begin
                cmd.step   = !done_now;
                cmd.finish = done_now & slot_free;
                cmd.result = stat.restart | stat.count_zero | !stat.hit;
                in_ready   = cmd.finish;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load = in_valid & in_ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (cmd.finish && !cmd.load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result register is filled on finish and emptied when the result is taken.
    assign out_valid_next = cmd.finish | (out_valid_reg & !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/zsr_datapath.sv */
// Datapath: committed and working reach sets, the translation network and the result bit.
`default_nettype none

module zsr_datapath
    import zsr_pkg::*;
#(
    parameter int MAX_LEN = 5
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_cmd_t  cmd,
    input  wire logic       func,
    input  wire logic [6:0] element,
    input  wire logic [2:0] copies,
    output dp_stat_t        stat,
    output logic            accepted
);

    set_t        reach_reg  [0:MAX_LEN];
    set_t        reach_next [0:MAX_LEN];
    set_t        cur_reg    [0:MAX_LEN];
    set_t        cur_next   [0:MAX_LEN];
    set_t        nxt        [0:MAX_LEN];
    set_t        shifted    [0:MAX_LEN-1];
    elem_coord_t coord_reg;
    elem_coord_t coord_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        func_reg;
    logic        func_next;
    logic        accepted_reg;
    logic        accepted_next;
    logic        hit;

    // One copy: translate every shorter set by the element and merge into the next length.
    always_comb
    begin
        hit    = 1'b0;
        nxt[0] = cur_reg[0];
        for (int l = 0; l < MAX_LEN; l++)
        begin
            shifted[l] = shift_set(cur_reg[l], coord_reg);
            hit        = hit | shifted[l][0];
            nxt[l+1]   = cur_reg[l+1] | shifted[l];
        end
    end

    assign stat.restart    = !func_reg;
    assign stat.count_zero = (count_reg == 3'd0);
    assign stat.count_last = (count_reg == 3'd1);
    assign stat.hit        = hit;

    // Commit: a restart clears the sets, a clean last copy stores its result.
    always_comb
    begin
        for (int l = 0; l <= MAX_LEN; l++)
        begin
            reach_next[l] = reach_reg[l];
            if (cmd.finish)
            begin
                if (!func_reg)
                begin
                    reach_next[l] = (l == 0) ? ZERO_ONLY_SET : EMPTY_SET;
                end
                else if (stat.count_last && !hit)
                begin
                    reach_next[l] = nxt[l];
                end
            end
        end
    end

    // Working copy starts from the state as it stands after any commit in the same cycle.
    always_comb
    begin
        for (int l = 0; l <= MAX_LEN; l++)
        begin
            if (cmd.load)
            begin
                cur_next[l] = reach_next[l];
            end
            else if (cmd.step)
            begin
                cur_next[l] = nxt[l];
            end
            else
            begin
                cur_next[l] = cur_reg[l];
            end
        end
    end

    // Item fields and the copy counter.
    always_comb
    begin
        func_next  = func_reg;
        coord_next = coord_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            func_next  = func;
            coord_next = elem_coords(element);
            count_next = copies;
        end
        else if (cmd.step)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    assign accepted_next = cmd.finish ? cmd.result : accepted_reg;

    // Committed sets come out of reset holding the empty sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l <= MAX_LEN; l++)
            begin
                reach_reg[l] <= (l == 0) ? ZERO_ONLY_SET : EMPTY_SET;
            end
            count_reg <= 3'd0;
            func_reg  <= 1'b1;
        end
        else
        begin
            for (int l = 0; l <= MAX_LEN; l++)
            begin
                reach_reg[l] <= reach_next[l];
            end
            count_reg <= count_next;
            func_reg  <= func_next;
        end
    end

    // Working sets, coordinates and result bit carry no reset.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l <= MAX_LEN; l++)
        begin
            cur_reg[l] <= cur_next[l];
        end
        coord_reg    <= coord_next;
        accepted_reg <= accepted_next;
    end

    assign accepted = accepted_reg;

endmodule

`default_nettype wire

/* hdl/zero_sum_reach_set_update_top.sv */
// Top level of the zero-sum reach-set block: controller, datapath and checks.
`default_nettype none

// For each length 0 to MAX_LEN the block holds the set of Z5^3 elements that are sums
// of exactly that many members of the accepted sequence; it comes out of reset with
// only zero at length zero. An add item (func 1) appends copies of an element and
// answers accepted 0, leaving the sets untouched, if any copy would make zero a sum of
// 1 to MAX_LEN members; a restart item (func 0) returns to the empty sequence and
// answers 1. A kept add item applies its copies in turn, each copy passing every
// length through the translation network, and a refused add ends in the cycle of
// the first copy that reaches zero. The result appears in the cycle after the
// item's last cycle, and the next item is taken in that last cycle, so back-to-back
// items follow one another with no idle state between them.
// A result not taken holds the block in its last cycle until the result register is
// free.
module zero_sum_reach_set_update_top
    import zsr_pkg::*;
#(
    parameter int MAX_LEN = 5
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    zsr_req_if.sink    req,
    zsr_rsp_if.source  rsp
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      in_ready;
    logic      out_valid;
    logic      accepted;

    zsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    zsr_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .func     (req.func),
        .element  (req.element),
        .copies   (req.copies),
        .stat     (stat),
        .accepted (accepted)
    );

    assign req.ready    = in_ready;
    assign rsp.valid    = out_valid;
    assign rsp.accepted = accepted;

    // A restart always answers with an accepted result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && stat.restart |=> rsp.accepted)
        else $error("restart item did not answer accepted");

    // A finishing item never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp.valid || rsp.ready))
        else $error("result register overwritten");

    // A copy is folded into the working sets only when it is clean and not the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!stat.hit && !stat.count_last && !stat.restart && !cmd.finish))
        else $error("copy stepped on a finishing item");

endmodule

`default_nettype wire
